// ===== rtl/signed_divide_64_by_32_macros.svh =====
// assertion helpers for the divider
`ifndef SIGNED_DIVIDE_64_BY_32_MACROS_SVH
`define SIGNED_DIVIDE_64_BY_32_MACROS_SVH

// same-cycle implication, checked outside reset
`define SD64_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SD64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sd64_pkg.sv =====
package sd64_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 32;
    localparam int NUM_STEPS  = DIVIDEND_W;

    // payload carried from cell to cell
    typedef struct packed {
        logic [DIVIDEND_W-1:0] num;   // dividend magnitude, next bit at the top
        logic [DIVISOR_W-1:0]  rem;   // partial remainder, below den unless the divisor is zero
        logic [DIVISOR_W-1:0]  den;   // divisor magnitude
        logic [DIVISOR_W-1:0]  quo;   // quotient bits gathered so far
        logic                  neg;   // result must be negated
        logic                  zero;  // divisor was zero
    } sd64_stage_t;

endpackage

// ===== rtl/sd64_front.sv =====
module sd64_front
    import sd64_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output logic                   out_valid,
    output sd64_stage_t            out_stage
);

    logic        valid_reg;
    sd64_stage_t stage_reg;
    sd64_stage_t stage_next;

    // sign and magnitude of both operands
    always_comb
    begin
        stage_next.num  = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
        stage_next.den  = divisor[DIVISOR_W-1] ? (~divisor + 1'b1) : divisor;
        stage_next.rem  = '0;
        stage_next.quo  = '0;
        stage_next.neg  = dividend[DIVIDEND_W-1] ^ divisor[DIVISOR_W-1];
        stage_next.zero = (divisor == '0);
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/sd64_cell.sv =====
module sd64_cell
    import sd64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         in_valid,
    input  sd64_stage_t  in_stage,
    output logic         out_valid,
    output sd64_stage_t  out_stage
);

    logic                 valid_reg;
    sd64_stage_t          stage_reg;
    sd64_stage_t          stage_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W+1:0] diff;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb
    begin
        shifted = {in_stage.rem, in_stage.num[DIVIDEND_W-1]};
        diff    = {1'b0, shifted} - {2'b00, in_stage.den};
        fits    = ~diff[DIVISOR_W+1];

        stage_next      = in_stage;
        stage_next.num  = {in_stage.num[DIVIDEND_W-2:0], 1'b0};
        stage_next.rem  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        stage_next.quo  = {in_stage.quo[DIVISOR_W-2:0], fits};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/signed_divide_64_by_32.sv =====
// Signed 64-by-32 divider, quotient truncated toward zero.
// Input channel: in_valid/in_ready carry dividend (64 bits) and divisor
// (32 bits), both two's complement. Output channel: out_valid/out_ready
// carry quotient, the low 32 bits of the true quotient; wider quotients
// wrap without any flag, and a zero divisor gives 0. No remainder.
// Structure: a sign/magnitude register, a row of 64 restoring-division
// cells (one quotient bit per cell, one per dividend bit), and the output
// register that applies the sign.
// Order: the input register loads at the accepting edge, then the beat
// passes through the 64 cells in turn and into the output register.
// Throughput: one beat per cycle; a new beat enters every cycle while the
// output is taken.
// Stall: when out_valid is high and out_ready low, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
// Reset: rst_n clears all valid flags, so the pipeline comes up empty
// and ready to accept.
module signed_divide_64_by_32
    import sd64_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIVISOR_W-1:0]  quotient
);

`include "signed_divide_64_by_32_macros.svh"

    logic                 advance;
    logic [NUM_STEPS:0]   valid_chain;
    sd64_stage_t          stage_chain [NUM_STEPS+1];
    logic                 out_valid_reg;
    logic [DIVISOR_W-1:0] quotient_reg;
    logic [DIVISOR_W-1:0] quotient_next;
    sd64_stage_t          last_stage;

    // pipeline moves whenever the output register is free or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // operand signs and magnitudes
    sd64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (valid_chain[0]),
        .out_stage (stage_chain[0])
    );

    // row of division cells
    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_cell
        sd64_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (valid_chain[i]),
            .in_stage  (stage_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_stage (stage_chain[i+1])
        );
    end

    assign last_stage = stage_chain[NUM_STEPS];

    // sign fix-up and zero-divisor override
    always_comb
    begin
        if (last_stage.zero)
        begin
            quotient_next = '0;
        end
        else if (last_stage.neg)
        begin
            quotient_next = ~last_stage.quo + 1'b1;
        end
        else
        begin
            quotient_next = last_stage.quo;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid_chain[NUM_STEPS];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quotient_reg <= quotient_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign quotient  = quotient_reg;

    // dividend magnitude never exceeds 2^63
    `SD64_ASSERT_NOW(a_mag_range, valid_chain[0] && stage_chain[0].num[DIVIDEND_W-1],
        stage_chain[0].num[DIVIDEND_W-2:0] == '0, "dividend magnitude above 2^63")

    // restoring step keeps the remainder below the divisor
    `SD64_ASSERT_NOW(a_rem_bound, valid_chain[NUM_STEPS] && !last_stage.zero,
        last_stage.rem < last_stage.den, "remainder not below divisor")

    // a held pipeline keeps its last stage unchanged
    `SD64_ASSERT_NEXT(a_hold, !advance,
        $stable(valid_chain[NUM_STEPS]) && $stable(last_stage), "pipeline moved while held")

endmodule
